// ----- rtl/mbrm_pkg.sv -----
// Shared types, codes and the CRC-16/Modbus byte update for the Modbus RTU master.
// No dependencies.
`timescale 1ns / 1ps

package mbrm_pkg;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SEND  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_WHI   = 9'b000010000,
        S_WLO   = 9'b000100000,
        S_WEMIT = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_TOUT  = 9'b100000000
    } t_state;

    // input operations
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_RXBYTE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // done status
    localparam logic [1:0] ST_ACK   = 2'd0;
    localparam logic [1:0] ST_EXC   = 2'd1;
    localparam logic [1:0] ST_NOANS = 2'd2;

    // function codes
    localparam logic [7:0] FC_READ     = 8'h03;
    localparam logic [7:0] FC_WRITE    = 8'h06;
    localparam logic [7:0] FC_WRITE_SP = 8'h09;
    localparam logic [7:0] EXC_MARK_HI = 8'h80;
    localparam logic [7:0] EXC_MARK_LO = 8'h01;

    // config register indexes
    localparam logic [1:0] CFG_GAP     = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_RETRY   = 2'd2;
    localparam logic [1:0] CFG_SPECIAL = 2'd3;

    localparam logic [4:0] MAX_WORDS = 5'd29;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/mbrm_rxbuf.sv -----
// Receive byte buffer: one write port, one registered read port.
// Uses no package.
`timescale 1ns / 1ps

module mbrm_rxbuf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/modbus_rtu_master_transaction.sv -----
// Modbus RTU master transaction engine, top level.
// Depends on mbrm_pkg and mbrm_rxbuf.
`timescale 1ns / 1ps

// Usage: one input word at a time. A start emits the 8 request bytes (CRC low
// byte first), one per cycle when the output is not stalled; the CRC is
// updated a byte per cycle alongside them. A received byte is taken without
// leaving idle. A tick passes through the timeout state; when it ends a frame,
// the receive buffer is CRC-scanned (one memory read per byte), then each read
// data word is read back from the same single port. Results wait in one
// output register; input stall is high while an item is being worked on.
// Config writes are always ready.
module modbus_rtu_master_transaction #(
    parameter int RX_BUF_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_slave_address,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_value_or_count,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_data_word,
    output logic [4:0]  o_word_offset,
    output logic [1:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mbrm_pkg::*;

    localparam int AW = $clog2(RX_BUF_BYTES);
    localparam int FW = $clog2(RX_BUF_BYTES + 1);

    // config
    logic [15:0] r_gap_ticks, r_timeout;
    logic [3:0]  r_retry_limit;
    logic [7:0]  r_special;

    // transaction state
    t_state      r_state;
    logic [FW-1:0] r_fill, r_len, r_cnt;
    logic [15:0] r_gap, r_wait_timer, r_crc;
    logic [3:0]  r_attempts;
    logic        r_wait, r_rcv;
    logic [7:0]  r_slave, r_func;
    logic [15:0] r_reg, r_val;
    logic [2:0]  r_sidx;
    logic [7:0]  r_b0, r_b1, r_b2, r_b3, r_b5, r_hi;
    logic [4:0]  r_words, r_widx;
    logic [1:0]  r_status;
    logic [7:0]  r_exc;

    // output register
    logic        r_out_valid, r_out_last;
    logic [1:0]  r_out_kind, r_out_status;
    logic [7:0]  r_out_tx, r_out_exc;
    logic [15:0] r_out_word;
    logic [4:0]  r_out_off;

    logic          w_accept, w_slot, w_we, w_emit;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata, w_tx;
    logic [6:0]    w_hi_idx, w_lo_idx;
    logic [15:0]   w_gap_inc, w_wait_inc;
    logic [FW-1:0] w_scan_idx, w_avail;
    logic [7:0]    w_cnt_min;
    logic          w_fmatch;

    assign w_accept  = i_valid && !o_stall;
    assign w_slot    = !r_out_valid || !i_stall;
    // a result is loaded into the output register this cycle
    assign w_emit    = w_slot && ((r_state == S_SEND) || (r_state == S_WEMIT) ||
                                  (r_state == S_DONE));
    assign w_we      = w_accept && (i_operation == OP_RXBYTE) &&
                       (r_fill < FW'(RX_BUF_BYTES));
    assign w_hi_idx  = {1'b0, r_widx, 1'b0} + 7'd3;
    assign w_lo_idx  = {1'b0, r_widx, 1'b0} + 7'd4;
    assign w_raddr   = (r_state == S_SCAN) ? r_cnt[AW-1:0] :
                       (r_state == S_WHI)  ? AW'(w_hi_idx) : AW'(w_lo_idx);
    assign w_gap_inc  = (r_gap == 16'hFFFF) ? r_gap : r_gap + 16'd1;
    assign w_wait_inc = (r_wait_timer == 16'hFFFF) ? r_wait_timer : r_wait_timer + 16'd1;
    assign w_scan_idx = r_cnt - FW'(1);
    assign w_avail    = (r_len >= FW'(5)) ? ((r_len - FW'(5)) >> 1) : '0;
    assign w_cnt_min  = ({1'b0, r_b2[7:1]} < 8'(w_avail)) ? {1'b0, r_b2[7:1]} : 8'(w_avail);
    assign w_fmatch   = (r_func == FC_READ) ? (r_b1 == FC_READ) :
                        (r_b1 == FC_WRITE || r_b1 == FC_WRITE_SP);

    always_comb begin
        case (r_sidx)
            3'd0:    w_tx = r_slave;
            3'd1:    w_tx = r_func;
            3'd2:    w_tx = r_reg[15:8];
            3'd3:    w_tx = r_reg[7:0];
            3'd4:    w_tx = r_val[15:8];
            3'd5:    w_tx = r_val[7:0];
            3'd6:    w_tx = r_crc[7:0];
            default: w_tx = r_crc[15:8];
        endcase
    end

    mbrm_rxbuf #(.DEPTH(RX_BUF_BYTES), .AW(AW)) u_rxbuf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks   <= 16'd4;
            r_timeout     <= 16'd50;
            r_retry_limit <= 4'd3;
            r_special     <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAP:     r_gap_ticks   <= i_cfg_data;
                CFG_TIMEOUT: r_timeout     <= i_cfg_data;
                CFG_RETRY:   r_retry_limit <= i_cfg_data[3:0];
                CFG_SPECIAL: r_special     <= i_cfg_data[7:0];
                default:     r_gap_ticks   <= r_gap_ticks;
            endcase
        end
    end

    // output valid: set on load, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_gap        <= '0;
            r_wait_timer <= '0;
            r_attempts   <= '0;
            r_wait       <= 1'b0;
            r_rcv        <= 1'b0;
            r_slave      <= '0;
            r_func       <= '0;
            r_reg        <= '0;
            r_val        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_operation)
                            OP_READ, OP_WRITE: begin
                                if (!r_wait) begin
                                    r_slave    <= i_slave_address;
                                    r_reg      <= i_register_address;
                                    r_val      <= i_value_or_count;
                                    r_func     <= (i_operation == OP_READ) ? FC_READ :
                                                  (i_slave_address == r_special) ?
                                                  FC_WRITE_SP : FC_WRITE;
                                    r_attempts <= 4'd1;
                                    r_wait     <= 1'b1;
                                    r_sidx     <= '0;
                                    r_crc      <= 16'hFFFF;
                                    r_state    <= S_SEND;
                                end
                            end
                            OP_RXBYTE: begin
                                if (r_fill < FW'(RX_BUF_BYTES)) begin
                                    r_fill <= r_fill + FW'(1);
                                end
                                r_gap <= '0;
                                r_rcv <= 1'b1;
                            end
                            default: begin
                                if (r_rcv && (w_gap_inc >= r_gap_ticks)) begin
                                    // frame end
                                    r_len  <= r_fill;
                                    r_fill <= '0;
                                    r_rcv  <= 1'b0;
                                    r_gap  <= '0;
                                    if (r_wait) begin
                                        r_wait_timer <= '0;
                                    end
                                    if (r_wait && (r_fill >= FW'(4))) begin
                                        r_cnt   <= '0;
                                        r_crc   <= 16'hFFFF;
                                        r_state <= S_SCAN;
                                    end else begin
                                        r_state <= S_TOUT;
                                    end
                                end else begin
                                    if (r_rcv) begin
                                        r_gap <= w_gap_inc;
                                    end
                                    r_state <= S_TOUT;
                                end
                            end
                        endcase
                    end
                end
                S_SEND: begin
                    if (w_slot) begin
                        r_out_kind   <= KIND_TX;
                        r_out_tx     <= w_tx;
                        r_out_word   <= '0;
                        r_out_off    <= '0;
                        r_out_status <= ST_ACK;
                        r_out_exc    <= '0;
                        r_out_last   <= (r_sidx == 3'd7);
                        if (r_sidx < 3'd6) begin
                            r_crc <= crc_byte(r_crc, w_tx);
                        end
                        r_sidx <= r_sidx + 3'd1;
                        if (r_sidx == 3'd7) begin
                            r_wait_timer <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_SCAN: begin
                    // data for index r_cnt-1 arrives this cycle
                    if (r_cnt != '0) begin
                        r_crc <= crc_byte(r_crc, w_rdata);
                        if (w_scan_idx == FW'(0)) r_b0 <= w_rdata;
                        if (w_scan_idx == FW'(1)) r_b1 <= w_rdata;
                        if (w_scan_idx == FW'(2)) r_b2 <= w_rdata;
                        if (w_scan_idx == FW'(3)) r_b3 <= w_rdata;
                        if (w_scan_idx == FW'(5)) r_b5 <= w_rdata;
                    end
                    if (r_cnt == r_len) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + FW'(1);
                    end
                end
                S_CHECK: begin
                    if (r_crc == '0 && r_b0 == r_slave && w_fmatch) begin
                        r_wait <= 1'b0;
                        r_widx <= '0;
                        if (r_b2 == EXC_MARK_HI && r_b3 == EXC_MARK_LO) begin
                            r_status <= ST_EXC;
                            r_exc    <= (r_len >= FW'(6)) ? r_b5 : 8'd0;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_ACK;
                            r_exc    <= '0;
                            if (r_func == FC_READ) begin
                                r_words <= (w_cnt_min > 8'(MAX_WORDS)) ? MAX_WORDS :
                                           w_cnt_min[4:0];
                                r_state <= (w_cnt_min != 8'd0) ? S_WHI : S_DONE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        r_state <= S_TOUT;
                    end
                end
                S_WHI: r_state <= S_WLO;
                S_WLO: begin
                    r_hi    <= w_rdata;
                    r_state <= S_WEMIT;
                end
                S_WEMIT: begin
                    if (w_slot) begin
                        r_out_kind   <= KIND_WORD;
                        r_out_tx     <= '0;
                        r_out_word   <= {r_hi, w_rdata};
                        r_out_off    <= r_widx;
                        r_out_status <= ST_ACK;
                        r_out_exc    <= '0;
                        r_out_last   <= 1'b0;
                        r_widx       <= r_widx + 5'd1;
                        r_state      <= (r_widx + 5'd1 == r_words) ? S_DONE : S_WHI;
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_out_kind   <= KIND_DONE;
                        r_out_tx     <= '0;
                        r_out_word   <= '0;
                        r_out_off    <= '0;
                        r_out_status <= r_status;
                        r_out_exc    <= r_exc;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_TOUT: begin
                    if (r_wait && (w_wait_inc >= r_timeout)) begin
                        if (r_attempts >= r_retry_limit) begin
                            r_wait       <= 1'b0;
                            r_wait_timer <= '0;
                            r_status     <= ST_NOANS;
                            r_exc        <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_wait_timer <= w_wait_inc;
                            r_attempts   <= r_attempts + 4'd1;
                            r_sidx       <= '0;
                            r_crc        <= 16'hFFFF;
                            r_state      <= S_SEND;
                        end
                    end else begin
                        if (r_wait) begin
                            r_wait_timer <= w_wait_inc;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_tx_byte        = r_out_tx;
    assign o_data_word      = r_out_word;
    assign o_word_offset    = r_out_off;
    assign o_status         = r_out_status;
    assign o_exception_code = r_out_exc;
    assign o_last           = r_out_last;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RX_BUF_BYTES))
        else $error("receive fill past buffer depth");
    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> r_wait)
        else $error("request sent while not waiting for reply");
    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WEMIT) |-> (r_widx < r_words))
        else $error("data word index past word count");
`endif
endmodule

// ----- tb/sv/modbus_rtu_master_transaction_test.sv -----
// Self-checking testbench for the Modbus RTU master transaction engine.
// Depends on mbrm_pkg and the modbus_rtu_master_transaction RTL; predicts every result locally.
`timescale 1ns / 1ps

module modbus_rtu_master_transaction_test;
    import mbrm_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  slave;
        logic [15:0] reg_addr;
        logic [15:0] value;
        logic [7:0]  rx_byte;
    } t_line_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] data_word;
        logic [4:0]  word_offset;
        logic [1:0]  status;
        logic [7:0]  exc_code;
        logic        last;
    } t_master_result;

    localparam int RX_BYTES   = 64;
    localparam int SETTLE_CYC = 250;  // frame scan plus 29 data words, with margin

    // DUT signals; the inputs are known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = OP_TICK;
    logic [7:0]  i_slave_address = 8'h00;
    logic [15:0] i_register_address = 16'h0000;
    logic [15:0] i_value_or_count = 16'h0000;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [15:0] o_data_word;
    logic [4:0]  o_word_offset;
    logic [1:0]  o_status;
    logic [7:0]  o_exception_code;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_GAP;
    logic [15:0] i_cfg_data = 16'h0000;

    modbus_rtu_master_transaction dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model of the master: config copy and transaction state
    logic [15:0] mdl_gap_ticks;
    logic [15:0] mdl_timeout_ticks;
    logic [3:0]  mdl_retry_limit;
    logic [7:0]  mdl_special_addr;
    logic [7:0]  mdl_rx_buf [RX_BYTES];
    int          mdl_rx_len;
    int          mdl_gap_cnt;
    int          mdl_wait_cnt;
    int          mdl_attempts;
    logic        mdl_waiting;
    logic        mdl_receiving;
    logic [7:0]  req_slave;
    logic [7:0]  req_func;
    logic [15:0] req_reg;
    logic [15:0] req_val;

    t_line_word     line_word_q[$];   // words waiting for the driver
    t_master_result master_result_q[$];  // predicted results, oldest first

    int send_idle_pct = 15;
    int recv_idle_pct = 47;
    int mismatches = 0;
    int results_seen = 0;
    int words_seen = 0;
    int acks_seen = 0;
    int excs_seen = 0;
    int noans_seen = 0;
    int frames_sent = 0;

    function automatic logic [15:0] modbus_crc(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] txb,
                                        input logic [15:0] w, input logic [4:0] off,
                                        input logic [1:0] st, input logic [7:0] exc);
        t_master_result r;
        r = '{kind, txb, w, off, st, exc, 1'b0};
        master_result_q.push_back(r);
    endfunction

    function automatic void emit_request();
        logic [7:0]  f [6];
        logic [15:0] c;
        c = 16'hFFFF;
        f = '{req_slave, req_func, req_reg[15:8], req_reg[7:0], req_val[15:8], req_val[7:0]};
        foreach (f[i]) begin
            c = modbus_crc(c, f[i]);
            push_result(KIND_TX, f[i], 16'h0, 5'd0, ST_ACK, 8'h00);
        end
        push_result(KIND_TX, c[7:0], 16'h0, 5'd0, ST_ACK, 8'h00);
        push_result(KIND_TX, c[15:8], 16'h0, 5'd0, ST_ACK, 8'h00);
        mdl_wait_cnt = 0;
    endfunction

    // End of a received frame: validate and match against the open request
    function automatic void close_frame();
        int          len;
        int          nwords;
        int          avail;
        logic [15:0] c;
        logic        fmatch;
        len = mdl_rx_len;
        mdl_rx_len = 0;
        mdl_receiving = 1'b0;
        mdl_gap_cnt = 0;
        if (!mdl_waiting) return;
        mdl_wait_cnt = 0;
        if (len < 4) return;
        c = 16'hFFFF;
        for (int i = 0; i < len; i++) c = modbus_crc(c, mdl_rx_buf[i]);
        if (c != 16'h0000) return;
        if (mdl_rx_buf[0] != req_slave) return;
        if (req_func == FC_READ) fmatch = (mdl_rx_buf[1] == FC_READ);
        else fmatch = (mdl_rx_buf[1] == FC_WRITE) || (mdl_rx_buf[1] == FC_WRITE_SP);
        if (!fmatch) return;
        mdl_waiting = 1'b0;
        if (mdl_rx_buf[2] == EXC_MARK_HI && mdl_rx_buf[3] == EXC_MARK_LO) begin
            push_result(KIND_DONE, 8'h0, 16'h0, 5'd0, ST_EXC,
                        (len >= 6) ? mdl_rx_buf[5] : 8'h00);
            return;
        end
        if (req_func == FC_READ) begin
            nwords = mdl_rx_buf[2] / 2;
            avail = (len >= 5) ? (len - 5) / 2 : 0;
            if (nwords > avail) nwords = avail;
            if (nwords > MAX_WORDS) nwords = MAX_WORDS;
            for (int i = 0; i < nwords; i++)
                push_result(KIND_WORD, 8'h0, {mdl_rx_buf[3 + 2 * i], mdl_rx_buf[4 + 2 * i]},
                            i[4:0], ST_ACK, 8'h00);
        end
        push_result(KIND_DONE, 8'h0, 16'h0, 5'd0, ST_ACK, 8'h00);
    endfunction

    function automatic void predict_master(input t_line_word w);
        int prior_cnt;
        prior_cnt = master_result_q.size();
        case (w.op)
            OP_READ, OP_WRITE: begin
                if (!mdl_waiting) begin
                    req_slave = w.slave;
                    req_reg = w.reg_addr;
                    req_val = w.value;
                    if (w.op == OP_READ) req_func = FC_READ;
                    else req_func = (w.slave == mdl_special_addr) ? FC_WRITE_SP : FC_WRITE;
                    mdl_attempts = 1;
                    mdl_waiting = 1'b1;
                    emit_request();
                end
            end
            OP_RXBYTE: begin
                if (mdl_rx_len < RX_BYTES) begin
                    mdl_rx_buf[mdl_rx_len] = w.rx_byte;
                    mdl_rx_len++;
                end
                mdl_gap_cnt = 0;
                mdl_receiving = 1'b1;
            end
            default: begin
                // frame end first, then the response timeout
                if (mdl_receiving) begin
                    if (mdl_gap_cnt < 65535) mdl_gap_cnt++;
                    if (mdl_gap_cnt >= mdl_gap_ticks) close_frame();
                end
                if (mdl_waiting) begin
                    if (mdl_wait_cnt < 65535) mdl_wait_cnt++;
                    if (mdl_wait_cnt >= mdl_timeout_ticks) begin
                        if (mdl_attempts >= mdl_retry_limit) begin
                            mdl_waiting = 1'b0;
                            mdl_wait_cnt = 0;
                            push_result(KIND_DONE, 8'h0, 16'h0, 5'd0, ST_NOANS, 8'h00);
                        end else begin
                            mdl_attempts = (mdl_attempts + 1) & 15;
                            emit_request();
                        end
                    end
                end
            end
        endcase
        if (master_result_q.size() > prior_cnt)
            master_result_q[master_result_q.size() - 1].last = 1'b1;
    endfunction

    // Driver: present the next word once the current one is taken
    always @(posedge i_clk) begin
        t_line_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_master('{i_operation, i_slave_address, i_register_address,
                                 i_value_or_count, i_rx_byte});
            if (!i_valid || !o_stall) begin
                if (line_word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = line_word_q.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= w.op;
                    i_slave_address <= w.slave;
                    i_register_address <= w.reg_addr;
                    i_value_or_count <= w.value;
                    i_rx_byte <= w.rx_byte;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_master_result got;
        t_master_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_kind, o_tx_byte, o_data_word, o_word_offset, o_status,
                    o_exception_code, o_last};
            results_seen++;
            if (master_result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d tx=%02h word=%04h off=%0d st=%0d exc=%02h last=%0d",
                             got.kind, got.tx_byte, got.data_word, got.word_offset,
                             got.status, got.exc_code, got.last);
            end else begin
                want = master_result_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp kind=%0d tx=%02h word=%04h off=%0d st=%0d exc=%02h last=%0d, got kind=%0d tx=%02h word=%04h off=%0d st=%0d exc=%02h last=%0d",
                                 results_seen, want.kind, want.tx_byte, want.data_word,
                                 want.word_offset, want.status, want.exc_code, want.last,
                                 got.kind, got.tx_byte, got.data_word, got.word_offset,
                                 got.status, got.exc_code, got.last);
                end
                if (want.kind == KIND_WORD) words_seen++;
                if (want.kind == KIND_DONE && want.status == ST_ACK) acks_seen++;
                if (want.kind == KIND_DONE && want.status == ST_EXC) excs_seen++;
                if (want.kind == KIND_DONE && want.status == ST_NOANS) noans_seen++;
            end
        end
    end

    // Stimulus helpers; unused fields carry random filler
    int queued_words;

    function automatic void queue_word(input logic [1:0] op, input logic [7:0] s,
                                       input logic [15:0] ra, input logic [15:0] v,
                                       input logic [7:0] b);
        line_word_q.push_back('{op, s, ra, v, b});
        queued_words++;
    endfunction

    function automatic void queue_start(input logic [1:0] op, input logic [7:0] s,
                                        input logic [15:0] ra, input logic [15:0] v);
        queue_word(op, s, ra, v, 8'($urandom));
    endfunction

    function automatic void queue_ticks(input int n);
        repeat (n) queue_word(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom));
    endfunction

    // Send the bytes on the line, optionally closed with a good CRC
    function automatic void queue_frame(input logic [7:0] fb[$], input logic add_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (fb[i]) c = modbus_crc(c, fb[i]);
        if (add_crc) begin
            fb.push_back(c[7:0]);
            fb.push_back(c[15:8]);
        end
        foreach (fb[i])
            queue_word(OP_RXBYTE, 8'($urandom), 16'($urandom), 16'($urandom), fb[i]);
        frames_sent++;
    endfunction

    function automatic void read_reply(input logic [7:0] s, input int nw,
                                       input logic [7:0] count_byte);
        logic [7:0] fb[$];
        fb = '{s, FC_READ, count_byte};
        repeat (nw) begin
            fb.push_back(8'($urandom));
            fb.push_back(8'($urandom));
        end
        queue_frame(fb, 1'b1);
    endfunction

    function automatic void exc_reply(input logic [7:0] s, input logic [7:0] fc,
                                      input logic full);
        logic [7:0] fb[$];
        fb = '{s, fc, EXC_MARK_HI, EXC_MARK_LO};
        if (full) begin
            fb.push_back(8'($urandom));
            fb.push_back(8'($urandom));
        end
        queue_frame(fb, 1'b1);
    endfunction

    function automatic void write_reply(input logic [7:0] s, input logic [7:0] fc,
                                        input logic [15:0] ra, input logic [15:0] v);
        queue_frame('{s, fc, ra[15:8], ra[7:0], v[15:8], v[7:0]}, 1'b1);
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (line_word_q.size() != 0 || i_valid || master_result_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_GAP:     mdl_gap_ticks = data;
            CFG_TIMEOUT: mdl_timeout_ticks = data;
            CFG_RETRY:   mdl_retry_limit = data[3:0];
            default:     mdl_special_addr = data[7:0];
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // One random transaction: mostly well-formed exchanges, some broken or noise
    task automatic random_exchange();
        logic [7:0]  s;
        logic [15:0] ra;
        logic [15:0] v;
        logic [7:0]  fb[$];
        int          pick;
        int          nw;
        int          g;
        logic        is_read;
        g = (mdl_gap_ticks > 12) ? 12 : int'(mdl_gap_ticks);
        s = ($urandom_range(1)) ? mdl_special_addr : 8'($urandom);
        ra = 16'($urandom);
        is_read = $urandom_range(1);
        nw = $urandom_range(0, 31);
        v = is_read ? 16'(nw) : 16'($urandom);
        if ($urandom_range(9) == 0) v = 16'($urandom);
        queue_start(is_read ? OP_READ : OP_WRITE, s, ra, v);
        queue_ticks($urandom_range(0, 3));
        pick = $urandom_range(99);
        if (pick < 55) begin
            if (is_read)
                read_reply(s, nw, ($urandom_range(7) == 0) ? 8'($urandom) : 8'(2 * nw));
            else
                write_reply(s, (s == mdl_special_addr) ? FC_WRITE_SP : FC_WRITE, ra, v);
        end else if (pick < 67) begin
            exc_reply(s, is_read ? FC_READ : FC_WRITE, $urandom_range(3) != 0);
        end else if (pick < 75) begin
            // bad CRC
            fb = '{s, is_read ? FC_READ : FC_WRITE, 8'($urandom), 8'($urandom)};
            queue_frame(fb, 1'b0);
        end else if (pick < 83) begin
            // wrong slave or wrong function
            if ($urandom_range(1)) write_reply(s + 8'd1, FC_WRITE, ra, v);
            else write_reply(s, is_read ? FC_WRITE : FC_READ, ra, v);
        end else if (pick < 90) begin
            // line noise, often past the end of the buffer
            repeat ($urandom_range(1, 80)) fb.push_back(8'($urandom));
            queue_frame(fb, $urandom_range(1));
        end else begin
            // silence: let the request time out and retry
            queue_ticks((mdl_timeout_ticks <= 60) ? int'(mdl_timeout_ticks) + 1 : 20);
        end
        queue_ticks(g + $urandom_range(0, 2));
    endtask

    task automatic run_random(input int n_words);
        int stop_at;
        stop_at = queued_words + n_words;
        while (queued_words < stop_at) random_exchange();
    endtask

    initial begin
        mdl_gap_ticks = 16'd4;
        mdl_timeout_ticks = 16'd50;
        mdl_retry_limit = 4'd3;
        mdl_special_addr = 8'd0;
        foreach (mdl_rx_buf[i]) mdl_rx_buf[i] = 8'h00;
        mdl_rx_len = 0;
        mdl_gap_cnt = 0;
        mdl_wait_cnt = 0;
        mdl_attempts = 0;
        mdl_waiting = 1'b0;
        mdl_receiving = 1'b0;
        {req_slave, req_func, req_reg, req_val} = '0;
        queued_words = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config: special-address write, ignored start,
        // read reply, short exception, full retry sequence
        queue_start(OP_WRITE, 8'h00, 16'h0000, 16'hFFFF);
        write_reply(8'h00, FC_WRITE_SP, 16'h0000, 16'hFFFF);
        queue_ticks(4);
        queue_start(OP_READ, 8'hFF, 16'hFFFF, 16'h0002);
        queue_start(OP_WRITE, 8'h55, 16'h1234, 16'h5678);
        read_reply(8'hFF, 2, 8'h04);
        queue_ticks(4);
        queue_start(OP_READ, 8'h11, 16'h8000, 16'h0001);
        exc_reply(8'h11, FC_READ, 1'b0);
        queue_ticks(4);
        queue_start(OP_WRITE, 8'h7E, 16'hA5A5, 16'h5A5A);
        queue_ticks(150);
        wait_idle();

        run_random(50);
        wait_idle();  // sender holds until every result is back
        run_random(30);
        wait_idle();

        // Low extremes
        write_cfg(CFG_GAP, 16'd1);
        write_cfg(CFG_TIMEOUT, 16'd1);
        write_cfg(CFG_RETRY, 16'd1);
        write_cfg(CFG_SPECIAL, 16'd255);
        run_random(50);
        wait_idle();

        send_idle_pct = 47;
        recv_idle_pct = 15;
        write_cfg(CFG_GAP, 16'd3);
        write_cfg(CFG_TIMEOUT, 16'd30);
        write_cfg(CFG_RETRY, 16'd15);
        write_cfg(CFG_SPECIAL, 16'($urandom_range(255)));
        run_random(90);
        wait_idle();

        // High extremes: frames and timeouts never close here
        write_cfg(CFG_GAP, 16'hFFFF);
        write_cfg(CFG_TIMEOUT, 16'hFFFF);
        run_random(30);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CFG_GAP, 16'd2);
        write_cfg(CFG_TIMEOUT, 16'd40);
        write_cfg(CFG_RETRY, 16'd2);
        run_random(60);
        wait_idle();

        mismatches += master_result_q.size();
        $display("Covered %0d input words, %0d reply frames, %0d results checked",
                 queued_words, frames_sent, results_seen);
        $display("Done: %0d acknowledged, %0d exceptions, %0d no answer; %0d data words",
                 acks_seen, excs_seen, noans_seen, words_seen);
        if (mismatches == 0)
            $display("modbus_rtu_master_transaction_test: PASS");
        else
            $display("modbus_rtu_master_transaction_test: FAIL");
        $finish;
    end

    initial begin
        #30ms;
        $display("modbus_rtu_master_transaction_test: FAIL");
        $finish;
    end

endmodule

// ----- modbus_rtu_master_transaction.f -----
rtl/mbrm_pkg.sv
rtl/mbrm_rxbuf.sv
rtl/modbus_rtu_master_transaction.sv
tb/sv/modbus_rtu_master_transaction_test.sv
